// ===== hw/rtl/dodd_pkg.sv =====
// Shared types and constants for the delta-of-delta timestamp decoder.
package dodd_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int TIME_BITS      = 64;
  localparam int REPORT_BITS    = 32;

  // result queue: two slots for one item's results plus one in flight
  localparam int RES_DEPTH      = 3;
  localparam int RES_PTR_BITS   = 2;
  localparam int RES_LEVEL_BITS = 2;

  localparam logic KIND_TIME    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic REG_MIN_TIME = 1'b0;
  localparam logic REG_MAX_TIME = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [TIME_BITS-1:0]   ts;
    logic [REPORT_BITS-1:0] skipped;
    logic [REPORT_BITS-1:0] added;
    logic                   last;
  } result_t;

  // results handed to the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    first_res;
    result_t    second_res;
  } push_t;

endpackage

// ===== hw/rtl/dodd_result_fifo.sv =====
// Three-entry result queue that takes up to two results per cycle.
module dodd_result_fifo (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dodd_pkg::push_t                       push,
  input  logic                                  pop,
  output logic [dodd_pkg::RES_LEVEL_BITS-1:0]   level,
  output logic                                  head_valid,
  output dodd_pkg::result_t                     head
);

  dodd_pkg::result_t mem [dodd_pkg::RES_DEPTH];

  logic [dodd_pkg::RES_PTR_BITS-1:0]   wr_ptr;
  logic [dodd_pkg::RES_PTR_BITS-1:0]   rd_ptr;
  logic [dodd_pkg::RES_PTR_BITS-1:0]   wr_ptr_next;
  logic [dodd_pkg::RES_PTR_BITS-1:0]   wr_ptr_plus1;
  logic [dodd_pkg::RES_PTR_BITS-1:0]   rd_ptr_next;
  logic [dodd_pkg::RES_LEVEL_BITS-1:0] level_next;

  function automatic logic [dodd_pkg::RES_PTR_BITS-1:0] ptr_add(
    input logic [dodd_pkg::RES_PTR_BITS-1:0] p,
    input logic [1:0]                        n
  );
    logic [dodd_pkg::RES_PTR_BITS:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= (dodd_pkg::RES_PTR_BITS+1)'(dodd_pkg::RES_DEPTH)) begin
      s = s - (dodd_pkg::RES_PTR_BITS+1)'(dodd_pkg::RES_DEPTH);
    end
    return s[dodd_pkg::RES_PTR_BITS-1:0];
  endfunction

  assign head_valid   = (level != '0);
  assign head         = mem[rd_ptr];
  assign wr_ptr_plus1 = ptr_add(wr_ptr, 2'd1);
  assign wr_ptr_next  = ptr_add(wr_ptr, push.count);
  assign rd_ptr_next  = (pop && head_valid) ? ptr_add(rd_ptr, 2'd1) : rd_ptr;
  assign level_next   = level + push.count - {1'b0, (pop && head_valid)};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first_res;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_plus1] <= push.second_res;
    end
  end

endmodule

// ===== hw/rtl/delta_of_delta_time_decoder.sv =====
// Top level: delta-of-delta zigzag timestamp decoder with result queue.
//
//   port group   dir  handshake            payload
//   input        in   in_valid / in_stall   first_word, last_word, coded_word
//   result       out  out_valid / out_stall result_kind, timestamp, skipped_count,
//                                           added_count, last_result
//   config       in   write_en              write_index, write_data
//
// One word is taken per cycle while each word yields one result and the output
// does not stall. A word is held in the input register, where one three-input
// add and two compares decode it into the result queue. A word may yield two
// results (timestamp plus summary), which leave the queue one at a time. Reset
// clears the block state and the queue. The input stalls while the queue, not
// counting a result leaving that cycle, lacks room for the held word.
module delta_of_delta_time_decoder #(
  parameter int COUNT_BITS = dodd_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_en,
  input  logic                              write_index,
  input  logic [dodd_pkg::TIME_BITS-1:0]    write_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              first_word,
  input  logic                              last_word,
  input  logic [dodd_pkg::TIME_BITS-1:0]    coded_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              result_kind,
  output logic [dodd_pkg::TIME_BITS-1:0]    timestamp,
  output logic [dodd_pkg::REPORT_BITS-1:0]  skipped_count,
  output logic [dodd_pkg::REPORT_BITS-1:0]  added_count,
  output logic                              last_result
);

  typedef enum logic [1:0] {
    POS_START = 2'd0,
    POS_DELTA = 2'd1,
    POS_DOD   = 2'd2
  } pos_t;

  // configuration
  logic [dodd_pkg::TIME_BITS-1:0] min_time;
  logic [dodd_pkg::TIME_BITS-1:0] max_time;

  // input register
  logic                           item_valid;
  logic                           item_first;
  logic                           item_last;
  logic [dodd_pkg::TIME_BITS-1:0] item_word;

  // block state
  pos_t                           word_position;
  logic [dodd_pkg::TIME_BITS-1:0] running_time;
  logic [dodd_pkg::TIME_BITS-1:0] running_delta;
  logic [COUNT_BITS-1:0]          skipped_total;
  logic [COUNT_BITS-1:0]          added_total;
  logic                           stopped;

  // state as seen after a possible first-word clear
  pos_t                           cur_pos;
  logic [dodd_pkg::TIME_BITS-1:0] cur_time;
  logic [dodd_pkg::TIME_BITS-1:0] cur_delta;
  logic [COUNT_BITS-1:0]          cur_skipped;
  logic [COUNT_BITS-1:0]          cur_added;
  logic                           cur_stopped;

  logic [dodd_pkg::TIME_BITS-1:0] unzig;
  logic [dodd_pkg::TIME_BITS-1:0] time_next;
  logic [dodd_pkg::TIME_BITS-1:0] delta_next;
  logic [COUNT_BITS-1:0]          skipped_next;
  logic [COUNT_BITS-1:0]          added_next;
  pos_t                           pos_next;
  logic                           below_min;
  logic                           above_max;
  logic                           emit_time;
  logic                           emit_summary;
  logic [1:0]                     res_count;
  logic                           fire;

  dodd_pkg::push_t                        push;
  dodd_pkg::result_t                      time_res;
  dodd_pkg::result_t                      sum_res;
  dodd_pkg::result_t                      head;
  logic [dodd_pkg::RES_LEVEL_BITS-1:0]    level;
  logic                                   head_valid;
  logic                                   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_time <= '0;
      max_time <= '1;
    end else if (write_en) begin
      unique case (write_index)
        dodd_pkg::REG_MIN_TIME: min_time <= write_data;
        dodd_pkg::REG_MAX_TIME: max_time <= write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (item_first) begin
      cur_pos     = POS_START;
      cur_time    = '0;
      cur_delta   = '0;
      cur_skipped = '0;
      cur_added   = '0;
      cur_stopped = 1'b0;
    end else begin
      cur_pos     = word_position;
      cur_time    = running_time;
      cur_delta   = running_delta;
      cur_skipped = skipped_total;
      cur_added   = added_total;
      cur_stopped = stopped;
    end
  end

  assign unzig = (item_word >> 1) ^ {dodd_pkg::TIME_BITS{item_word[0]}};

  always_comb begin
    unique case (cur_pos)
      POS_START: begin
        delta_next = cur_delta;
        time_next  = item_word;
        pos_next   = POS_DELTA;
      end
      POS_DELTA: begin
        delta_next = unzig;
        time_next  = cur_time + unzig;
        pos_next   = POS_DOD;
      end
      default: begin
        delta_next = cur_delta + unzig;
        time_next  = cur_time + cur_delta + unzig;
        pos_next   = POS_DOD;
      end
    endcase
  end

  assign below_min    = (time_next < min_time);
  assign above_max    = (cur_pos == POS_DOD) && (time_next > max_time) && !below_min;
  assign emit_time    = !below_min && !above_max;
  assign emit_summary = above_max || item_last;

  assign skipped_next = (below_min && (cur_skipped != '1)) ? cur_skipped + 1'b1 : cur_skipped;
  assign added_next   = (emit_time && (cur_added != '1)) ? cur_added + 1'b1 : cur_added;

  assign res_count = cur_stopped ? 2'd0 : ({1'b0, emit_time} + {1'b0, emit_summary});

  // room check uses only registered values, so no stall path runs straight through
  assign fire     = item_valid &&
                    (({1'b0, level} + {1'b0, res_count}) <=
                     (dodd_pkg::RES_LEVEL_BITS+1)'(dodd_pkg::RES_DEPTH));
  assign in_stall = item_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_first <= first_word;
      item_last  <= last_word;
      item_word  <= coded_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= POS_START;
      running_time  <= '0;
      running_delta <= '0;
      skipped_total <= '0;
      added_total   <= '0;
      stopped       <= 1'b0;
    end else if (fire) begin
      if (cur_stopped) begin
        // a stopped block ignores the word; a first word never lands here
        stopped <= 1'b1;
      end else begin
        word_position <= pos_next;
        running_time  <= time_next;
        running_delta <= delta_next;
        skipped_total <= skipped_next;
        added_total   <= added_next;
        stopped       <= emit_summary;
      end
    end
  end

  always_comb begin
    time_res.kind    = dodd_pkg::KIND_TIME;
    time_res.ts      = time_next;
    time_res.skipped = dodd_pkg::REPORT_BITS'(skipped_next);
    time_res.added   = dodd_pkg::REPORT_BITS'(added_next);
    time_res.last    = !emit_summary;

    sum_res.kind     = dodd_pkg::KIND_SUMMARY;
    sum_res.ts       = '0;
    sum_res.skipped  = dodd_pkg::REPORT_BITS'(skipped_next);
    sum_res.added    = dodd_pkg::REPORT_BITS'(added_next);
    sum_res.last     = 1'b1;

    push.count      = fire ? res_count : 2'd0;
    push.first_res  = emit_time ? time_res : sum_res;
    push.second_res = sum_res;
  end

  assign pop = head_valid && !out_stall;

  dodd_result_fifo u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .level      (level),
    .head_valid (head_valid),
    .head       (head)
  );

  assign out_valid     = head_valid;
  assign result_kind   = head.kind;
  assign timestamp     = head.ts;
  assign skipped_count = head.skipped;
  assign added_count   = head.added;
  assign last_result   = head.last;

endmodule
